@@ rtl/ctf_pkg.sv @@
// Shared types, constants and the arctangent table for the complementary tilt filter.
// Used by ctf_cordic, ctf_ctrl, ctf_datapath and complementary_tilt_filter_unit.
package ctf_pkg;

    // Fixed configuration of the arithmetic.
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ATAN_FRAC       = 24;
    localparam int RND_SH          = ATAN_FRAC - ANGLE_FRAC_BITS;
    localparam int BLEND_FRAC      = 16;

    localparam int IN_W     = 16;
    localparam int ANGLE_W  = 28;
    localparam int BLEND_W  = 17;
    localparam int GAIN_W   = 24;
    localparam int CW       = 44;                    // CORDIC x and y
    localparam int ZW       = 34;                    // CORDIC angle, degrees Q.24
    localparam int ACC_W    = 10 + ANGLE_FRAC_BITS;  // accelerometer tilt angle
    localparam int PROD_W   = IN_W + GAIN_W + 1;     // gyro rate times gain
    localparam int GA_W     = (PROD_W + 1 - RND_SH > ANGLE_W + 1) ?
                              (PROD_W + 1 - RND_SH) : (ANGLE_W + 1);
    localparam int WT_W     = BLEND_W + 1;
    localparam int PA_W     = WT_W + GA_W;
    localparam int PB_W     = WT_W + ACC_W;
    localparam int SUM_W    = PA_W + 1;
    localparam int CNT_W    = $clog2(CORDIC_STEPS);
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

    localparam logic [BLEND_W-1:0] BLEND_ONE   = 17'd65536;
    localparam logic [BLEND_W-1:0] BLEND_RESET = 17'd58982;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd83886;

    // Axis codes.
    localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;

    localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180) <<< ATAN_FRAC;
    localparam logic signed [ZW-1:0] Z_HALF =
        {{(ZW - RND_SH){1'b0}}, 1'b1, {(RND_SH - 1){1'b0}}};
    localparam logic signed [PROD_W:0] PROD_HALF =
        {{(PROD_W + 1 - RND_SH){1'b0}}, 1'b1, {(RND_SH - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] BLEND_HALF =
        {{(SUM_W - BLEND_FRAC){1'b0}}, 1'b1, {(BLEND_FRAC - 1){1'b0}}};

    typedef logic [4:0] atan_idx_t;

    typedef struct packed {
        logic signed [IN_W-1:0] accel_x;
        logic signed [IN_W-1:0] accel_y;
        logic signed [IN_W-1:0] accel_z;
        logic signed [IN_W-1:0] gyro_x;
        logic signed [IN_W-1:0] gyro_y;
        logic signed [IN_W-1:0] gyro_z;
    } in_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_deg;
        logic signed [ANGLE_W-1:0] pitch_deg;
        logic signed [ANGLE_W-1:0] yaw_deg;
        logic                      saturated;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              cordic_en;
        logic [CNT_W-1:0]  step;
        logic              gyro_mul;
        logic              gyro_add;
        logic              fin;
        logic              blend_mul;
        logic              blend_add;
        logic [AXIS_W-1:0] mul_axis;
        logic [AXIS_W-1:0] add_axis;
        logic              out_load;
    } cmd_t;

    // atan(2^-i) in degrees, Q.24.
    function automatic logic signed [ZW-1:0] atan_deg(input atan_idx_t i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = ZW'(754974720);
            5'd1:  v = ZW'(445687602);
            5'd2:  v = ZW'(235489088);
            5'd3:  v = ZW'(119537938);
            5'd4:  v = ZW'(60000934);
            5'd5:  v = ZW'(30029717);
            5'd6:  v = ZW'(15018523);
            5'd7:  v = ZW'(7509720);
            5'd8:  v = ZW'(3754917);
            5'd9:  v = ZW'(1877466);
            5'd10: v = ZW'(938734);
            5'd11: v = ZW'(469367);
            5'd12: v = ZW'(234684);
            5'd13: v = ZW'(117342);
            5'd14: v = ZW'(58671);
            5'd15: v = ZW'(29335);
            5'd16: v = ZW'(14668);
            5'd17: v = ZW'(7334);
            5'd18: v = ZW'(3667);
            5'd19: v = ZW'(1833);
            5'd20: v = ZW'(917);
            5'd21: v = ZW'(458);
            5'd22: v = ZW'(229);
            5'd23: v = ZW'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/ctf_cordic.sv @@
// Iterative vectoring CORDIC giving atan2(num, den) in degrees, one step per cycle.
// Depends on ctf_pkg for widths, the half-turn constant and the arctangent table.
module ctf_cordic (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [ctf_pkg::IN_W:0]       num,
    input  logic signed [ctf_pkg::IN_W-1:0]     den,
    input  logic                                step_en,
    input  logic [ctf_pkg::CNT_W-1:0]           step,
    output logic signed [ctf_pkg::ACC_W-1:0]    angle
);

    logic signed [ctf_pkg::CW-1:0] x_reg, x_next;
    logic signed [ctf_pkg::CW-1:0] y_reg, y_next;
    logic signed [ctf_pkg::ZW-1:0] z_reg, z_next;
    logic                          zero_reg, zero_next;

    logic signed [ctf_pkg::IN_W+1:0] den_ext, num_ext, den_ld, num_ld;
    logic signed [ctf_pkg::CW-1:0]   x_sh, y_sh;
    logic signed [ctf_pkg::ZW-1:0]   z_step, z_rnd;
    logic                            den_neg;

    always_comb
    begin
        den_ext = (ctf_pkg::IN_W + 2)'(den);
        num_ext = (ctf_pkg::IN_W + 2)'(num);
        den_neg = den[ctf_pkg::IN_W-1];
        x_sh    = x_reg >>> step;
        y_sh    = y_reg >>> step;
        z_step  = ctf_pkg::atan_deg(ctf_pkg::atan_idx_t'(step));
        den_ld  = den_neg ? -den_ext : den_ext;
        num_ld  = den_neg ? -num_ext : num_ext;

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;

        if (load)
        begin
            // A vector in the left half plane is turned by half a turn first.
            x_next    = ctf_pkg::CW'(den_ld) <<< ctf_pkg::ATAN_FRAC;
            y_next    = ctf_pkg::CW'(num_ld) <<< ctf_pkg::ATAN_FRAC;
            zero_next = (num == '0) && (den == '0);
            if (!den_neg)
                z_next = '0;
            else if (num[ctf_pkg::IN_W])
                z_next = -ctf_pkg::Z_HALF_TURN;
            else
                z_next = ctf_pkg::Z_HALF_TURN;
        end
        else if (step_en)
        begin
            if (!y_reg[ctf_pkg::CW-1])
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + z_step;
            end
            else
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - z_step;
            end
        end

        z_rnd = z_reg + ctf_pkg::Z_HALF;
        angle = zero_reg ? '0 : ctf_pkg::ACC_W'(z_rnd >>> ctf_pkg::RND_SH);
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

endmodule

@@ rtl/ctf_datapath.sv @@
// Datapath: configuration registers, gyro integration, two CORDIC units, blend and clamp.
// Depends on ctf_pkg and ctf_cordic; driven by the command struct from ctf_ctrl.
module ctf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ctf_pkg::cmd_t                       cmd,
    input  ctf_pkg::in_t                        in_data,
    input  logic                                cfg_we,
    input  logic [ctf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ctf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ctf_pkg::out_t                       out_data
);

    localparam logic signed [ctf_pkg::SUM_W-1:0] SUM_MAX =
        {{(ctf_pkg::SUM_W - ctf_pkg::ANGLE_W + 1){1'b0}}, {(ctf_pkg::ANGLE_W - 1){1'b1}}};
    localparam logic signed [ctf_pkg::SUM_W-1:0] SUM_MIN =
        {{(ctf_pkg::SUM_W - ctf_pkg::ANGLE_W + 1){1'b1}}, {(ctf_pkg::ANGLE_W - 1){1'b0}}};

    logic [ctf_pkg::BLEND_W-1:0] blend_reg;
    logic [ctf_pkg::GAIN_W-1:0]  gain_reg;

    logic signed [ctf_pkg::ANGLE_W-1:0] angle_reg [ctf_pkg::NUM_AXES];
    logic                               sat_reg;

    logic signed [ctf_pkg::IN_W-1:0]    gyro_reg [ctf_pkg::NUM_AXES];
    logic signed [ctf_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ctf_pkg::GA_W-1:0]    ga_reg [ctf_pkg::NUM_AXES];
    logic signed [ctf_pkg::ACC_W-1:0]   roll_acc_reg, pitch_acc_reg;
    logic signed [ctf_pkg::PA_W-1:0]    pa_reg;
    logic signed [ctf_pkg::PB_W-1:0]    pb_reg;
    ctf_pkg::out_t                      out_reg;

    logic signed [ctf_pkg::ACC_W-1:0]   roll_cordic, pitch_cordic;
    logic signed [ctf_pkg::IN_W:0]      roll_num, pitch_num;

    logic signed [ctf_pkg::PROD_W-1:0]  prod_next;
    logic signed [ctf_pkg::PROD_W:0]    prod_rnd;
    logic signed [ctf_pkg::GA_W-1:0]    ga_next;
    logic [ctf_pkg::BLEND_W-1:0]        a_eff, b_eff;
    logic signed [ctf_pkg::WT_W-1:0]    wa, wb;
    logic signed [ctf_pkg::ACC_W-1:0]   acc_sel;
    logic signed [ctf_pkg::PA_W-1:0]    pa_next;
    logic signed [ctf_pkg::PB_W-1:0]    pb_next;
    logic signed [ctf_pkg::SUM_W-1:0]   sum, sum_sh;
    logic signed [ctf_pkg::ANGLE_W-1:0] angle_next;
    logic                               clamped;

    assign roll_num  = (ctf_pkg::IN_W + 1)'(in_data.accel_y);
    assign pitch_num = -((ctf_pkg::IN_W + 1)'(in_data.accel_x));

    ctf_cordic u_roll_cordic (
        .clk     (clk),
        .load    (cmd.load),
        .num     (roll_num),
        .den     (in_data.accel_z),
        .step_en (cmd.cordic_en),
        .step    (cmd.step),
        .angle   (roll_cordic)
    );

    ctf_cordic u_pitch_cordic (
        .clk     (clk),
        .load    (cmd.load),
        .num     (pitch_num),
        .den     (in_data.accel_z),
        .step_en (cmd.cordic_en),
        .step    (cmd.step),
        .angle   (pitch_cordic)
    );

    always_comb
    begin
        prod_next = gyro_reg[cmd.mul_axis] * $signed({1'b0, gain_reg});
        prod_rnd  = (ctf_pkg::PROD_W + 1)'(prod_reg) + ctf_pkg::PROD_HALF;
        ga_next   = ctf_pkg::GA_W'(angle_reg[cmd.add_axis])
                  + ctf_pkg::GA_W'(prod_rnd >>> ctf_pkg::RND_SH);

        // A blend factor above one acts as exactly one.
        a_eff = (blend_reg > ctf_pkg::BLEND_ONE) ? ctf_pkg::BLEND_ONE : blend_reg;
        b_eff = ctf_pkg::BLEND_ONE - a_eff;
        wa    = $signed({1'b0, a_eff});
        wb    = $signed({1'b0, b_eff});

        unique case (cmd.mul_axis)
            ctf_pkg::AXIS_ROLL:  acc_sel = roll_acc_reg;
            ctf_pkg::AXIS_PITCH: acc_sel = pitch_acc_reg;
            default:             acc_sel = '0;
        endcase

        pa_next = wa * ga_reg[cmd.mul_axis];
        pb_next = wb * acc_sel;

        sum    = ctf_pkg::SUM_W'(pa_reg) + ctf_pkg::SUM_W'(pb_reg) + ctf_pkg::BLEND_HALF;
        sum_sh = sum >>> ctf_pkg::BLEND_FRAC;
        if (sum_sh > SUM_MAX)
        begin
            angle_next = ctf_pkg::ANGLE_W'(SUM_MAX);
            clamped    = 1'b1;
        end
        else if (sum_sh < SUM_MIN)
        begin
            angle_next = ctf_pkg::ANGLE_W'(SUM_MIN);
            clamped    = 1'b1;
        end
        else
        begin
            angle_next = ctf_pkg::ANGLE_W'(sum_sh);
            clamped    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= ctf_pkg::BLEND_RESET;
            gain_reg  <= ctf_pkg::GAIN_RESET;
            for (int i = 0; i < ctf_pkg::NUM_AXES; i++)
            begin
                angle_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ctf_pkg::REG_BLEND: blend_reg <= cfg_data[ctf_pkg::BLEND_W-1:0];
                    ctf_pkg::REG_GAIN:  gain_reg  <= cfg_data[ctf_pkg::GAIN_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.blend_add)
                angle_reg[cmd.add_axis] <= angle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            gyro_reg[ctf_pkg::AXIS_ROLL]  <= in_data.gyro_x;
            gyro_reg[ctf_pkg::AXIS_PITCH] <= in_data.gyro_y;
            gyro_reg[ctf_pkg::AXIS_YAW]   <= in_data.gyro_z;
        end
        if (cmd.gyro_mul)
            prod_reg <= prod_next;
        if (cmd.gyro_add)
            ga_reg[cmd.add_axis] <= ga_next;
        if (cmd.fin)
        begin
            roll_acc_reg  <= roll_cordic;
            pitch_acc_reg <= pitch_cordic;
            sat_reg       <= 1'b0;
        end
        else if (cmd.blend_add)
            sat_reg <= sat_reg | clamped;
        if (cmd.blend_mul)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (cmd.out_load)
        begin
            out_reg.roll_deg  <= angle_reg[ctf_pkg::AXIS_ROLL];
            out_reg.pitch_deg <= angle_reg[ctf_pkg::AXIS_PITCH];
            out_reg.yaw_deg   <= angle_reg[ctf_pkg::AXIS_YAW];
            out_reg.saturated <= sat_reg;
        end
    end

    assign out_data = out_reg;

endmodule

@@ rtl/ctf_ctrl.sv @@
// Controller state machine: sequences load, CORDIC steps, gyro and blend passes and output.
// Depends on ctf_pkg for the command struct and the step count.
module ctf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output ctf_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_FIN   = 3'd2;
    localparam logic [2:0] S_BLEND = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [ctf_pkg::CNT_W-1:0] CNT_LAST  = ctf_pkg::CNT_W'(ctf_pkg::CORDIC_STEPS - 1);
    localparam logic [ctf_pkg::CNT_W-1:0] CNT_AXES  = ctf_pkg::CNT_W'(ctf_pkg::NUM_AXES);
    localparam logic [ctf_pkg::CNT_W-1:0] CNT_ONE   = ctf_pkg::CNT_W'(1);

    logic [2:0]                state_reg, state_next;
    logic [ctf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      in_first, in_second;
    logic [ctf_pkg::CNT_W-1:0] cnt_prev;

    always_comb
    begin
        // During the first passes of a phase, multiply on one axis while adding on the one before.
        in_first  = cnt_reg < CNT_AXES;
        in_second = (cnt_reg >= CNT_ONE) && (cnt_reg <= CNT_AXES);
        cnt_prev  = cnt_reg - CNT_ONE;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;

        cmd           = '0;
        cmd.step      = cnt_reg;
        cmd.mul_axis  = cnt_reg[ctf_pkg::AXIS_W-1:0];
        cmd.add_axis  = cnt_prev[ctf_pkg::AXIS_W-1:0];

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.cordic_en = 1'b1;
                cmd.gyro_mul  = in_first;
                cmd.gyro_add  = in_second;
                cnt_next      = cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_LAST)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                cnt_next   = '0;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                cmd.blend_mul = in_first;
                cmd.blend_add = in_second;
                cnt_next      = cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_AXES)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/complementary_tilt_filter_unit.sv @@
// Usage notes for the complementary tilt filter.
// The in channel (in_valid, in_ready, in_data) carries one IMU sample per item: three
// accelerometer and three gyro counts. The out channel (out_valid, out_ready, out_data)
// returns one item per sample: fused roll, pitch and yaw in degrees, Q11.16, and a flag
// set when any angle was clamped. The cfg channel writes blend_factor (index 0) and
// gyro_gain (index 1); other indices are ignored. cfg_ready is always high, and writes
// are expected only while no sample is in flight.
// After the accepting edge the controller runs the CORDIC steps with the gyro passes
// overlapped, a finish state, the blend passes and a done state that raises out_valid.
// Samples are taken only in idle; both CORDIC units take one step per cycle in parallel.
// The finished item sits in an output register, so the next sample is taken while it
// waits. If the receiver stalls, the following result holds in the datapath, with the
// controller waiting until the output register is free; no further sample is taken then.
// Reset clears the angles to zero, restores the default blend (0.9) and gain (0.005)
// and clears out_valid; the output register itself is not reset.
// Depends on ctf_pkg, ctf_ctrl, ctf_datapath and ctf_cordic.
module complementary_tilt_filter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ctf_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ctf_pkg::out_t                     out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ctf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ctf_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    ctf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ctf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
